FILE: hdl/assert_macros.svh
// Assertion macros used by the checker file of the sorter.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge outside reset.
`define SIBK_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("sorter port check failed");

// Next-cycle implication, sampled on the rising clock edge outside reset.
`define SIBK_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("sorter port check failed");

`endif

FILE: hdl/sibk_pkg.sv
// Package with shared constants and the chain control type of the sorter.
package sibk_pkg;

  // Default capacity of the chain and default internal key width.
  localparam int unsigned MaxItemsDefault = 64;
  localparam int unsigned KeyBitsDefault  = 32;

  // Fixed widths of the record fields on the ports.
  localparam int unsigned IdxW    = 6;
  localparam int unsigned KeyPortW = 32;

  // Control broadcast from the top level to every cell.
  typedef struct packed {
    logic insert_en;  // place the broadcast record into the chain
    logic drain_en;   // move every cell one place toward the output
  } sibk_ctrl_t;

endpackage

FILE: hdl/stable_index_sort_by_key.sv
// Top level of the stable index sorter: a chain of insertion cells.
//
// Records enter on the input channel, one beat per cycle while the input
// is not stalled, each an element index, a signed key and a last flag.
// Every accepted record is placed at once into a chain of MAX_ITEMS cells
// that stays sorted by key; a record goes behind all stored records with
// an equal or smaller key. Each cell decides with a single compare. The
// beat marked last starts the drain: the first result appears on the
// output channel in the next cycle and the chain then moves one cell
// toward the output per accepted output beat, one result per cycle when
// the receiver does not stall. The input is stalled during the drain.
// Records that arrive while the chain is full are dropped, and every result
// of that list carries the overflowed flag. A stalled output holds its
// beat and the chain does not move. Reset empties the chain at once.
module stable_index_sort_by_key #(
  parameter int unsigned MAX_ITEMS = sibk_pkg::MaxItemsDefault,
  parameter int unsigned KEY_BITS  = sibk_pkg::KeyBitsDefault
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic [sibk_pkg::IdxW-1:0]          element_index_i,
  input  logic signed [sibk_pkg::KeyPortW-1:0] sort_key_i,
  input  logic                               last_item_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic [sibk_pkg::IdxW-1:0]          sorted_index_o,
  output logic signed [sibk_pkg::KeyPortW-1:0] sorted_key_o,
  output logic                               last_result_o,
  output logic                               overflowed_o
);
  import sibk_pkg::*;

  logic                       cell_valid [MAX_ITEMS];
  logic                       cell_shift [MAX_ITEMS];
  logic signed [KEY_BITS-1:0] cell_key   [MAX_ITEMS];
  logic [IdxW-1:0]            cell_idx   [MAX_ITEMS];

  logic                       draining_q, draining_d;
  logic                       ovf_q, ovf_d;
  logic                       in_beat, out_beat, full, drain_done;
  logic signed [KEY_BITS-1:0] new_key;
  sibk_ctrl_t                 ctrl;

  // Key is brought to the internal width by sign extension or truncation.
  assign new_key = KEY_BITS'(sort_key_i);

  // Handshakes and chain control.
  assign in_stall_o     = draining_q;
  assign in_beat        = in_valid_i && !in_stall_o;
  assign out_valid_o    = draining_q && cell_valid[0];
  assign out_beat       = out_valid_o && !out_stall_i;
  assign full           = cell_valid[MAX_ITEMS-1];
  assign drain_done     = out_beat && !cell_valid[1];
  assign ctrl.insert_en = in_beat && !full;
  assign ctrl.drain_en  = out_beat;

  // Drain mode and overflow flag of the current list.
  always_comb begin
    draining_d = draining_q;
    ovf_d      = ovf_q;
    if (in_beat && last_item_i) begin
      draining_d = 1'b1;
    end else if (drain_done) begin
      draining_d = 1'b0;
    end
    if (drain_done) begin
      ovf_d = 1'b0;
    end else if (in_beat && full) begin
      ovf_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      draining_q <= 1'b0;
      ovf_q      <= 1'b0;
    end else begin
      draining_q <= draining_d;
      ovf_q      <= ovf_d;
    end
  end

  // The chain of cells; the first cell sees a valid, non-shifting left edge
  // and the last cell sees an empty right edge.
  for (genvar i = 0; i < MAX_ITEMS; i++) begin : g_cell
    logic                       lv, ls, rv;
    logic signed [KEY_BITS-1:0] lk, rk;
    logic [IdxW-1:0]            li, ri;

    if (i == 0) begin : g_left_edge
      assign lv = 1'b1;
      assign ls = 1'b0;
      assign lk = new_key;
      assign li = element_index_i;
    end else begin : g_left_link
      assign lv = cell_valid[i-1];
      assign ls = cell_shift[i-1];
      assign lk = cell_key[i-1];
      assign li = cell_idx[i-1];
    end

    if (i == MAX_ITEMS - 1) begin : g_right_edge
      assign rv = 1'b0;
      assign rk = cell_key[i];
      assign ri = cell_idx[i];
    end else begin : g_right_link
      assign rv = cell_valid[i+1];
      assign rk = cell_key[i+1];
      assign ri = cell_idx[i+1];
    end

    sibk_cell #(
      .KEY_BITS(KEY_BITS)
    ) u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctrl_i       (ctrl),
      .new_key_i    (new_key),
      .new_idx_i    (element_index_i),
      .left_valid_i (lv),
      .left_shift_i (ls),
      .left_key_i   (lk),
      .left_idx_i   (li),
      .right_valid_i(rv),
      .right_key_i  (rk),
      .right_idx_i  (ri),
      .valid_o      (cell_valid[i]),
      .shift_o      (cell_shift[i]),
      .key_o        (cell_key[i]),
      .idx_o        (cell_idx[i])
    );
  end

  // Result beat comes straight from the head cell.
  assign sorted_index_o = cell_idx[0];
  assign sorted_key_o   = KeyPortW'(cell_key[0]);
  assign last_result_o  = !cell_valid[1];
  assign overflowed_o   = ovf_q;

endmodule

FILE: hdl/sibk_cell.sv
// One cell of the insertion chain: holds a single record and its valid bit.
module sibk_cell #(
  parameter int unsigned KEY_BITS = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  sibk_pkg::sibk_ctrl_t          ctrl_i,
  input  logic signed [KEY_BITS-1:0]    new_key_i,
  input  logic [sibk_pkg::IdxW-1:0]     new_idx_i,
  input  logic                          left_valid_i,
  input  logic                          left_shift_i,
  input  logic signed [KEY_BITS-1:0]    left_key_i,
  input  logic [sibk_pkg::IdxW-1:0]     left_idx_i,
  input  logic                          right_valid_i,
  input  logic signed [KEY_BITS-1:0]    right_key_i,
  input  logic [sibk_pkg::IdxW-1:0]     right_idx_i,
  output logic                          valid_o,
  output logic                          shift_o,
  output logic signed [KEY_BITS-1:0]    key_o,
  output logic [sibk_pkg::IdxW-1:0]     idx_o
);
  import sibk_pkg::*;

  logic                       valid_q, valid_d;
  logic signed [KEY_BITS-1:0] key_q, key_d;
  logic [IdxW-1:0]            idx_q, idx_d;

  // A stored record moves right when its key is strictly greater than the
  // new one, so equal keys keep their arrival order.
  assign shift_o = valid_q && (key_q > new_key_i);

  // Next content: drain from the right, or take the left neighbor or the
  // new record during an insertion.
  always_comb begin
    valid_d = valid_q;
    key_d   = key_q;
    idx_d   = idx_q;
    if (ctrl_i.drain_en) begin
      valid_d = right_valid_i;
      key_d   = right_key_i;
      idx_d   = right_idx_i;
    end else if (ctrl_i.insert_en && (shift_o || !valid_q)) begin
      if (left_shift_i) begin
        valid_d = 1'b1;
        key_d   = left_key_i;
        idx_d   = left_idx_i;
      end else if (left_valid_i) begin
        valid_d = 1'b1;
        key_d   = new_key_i;
        idx_d   = new_idx_i;
      end
    end
  end

  // Valid bit is control state and is cleared by reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Record payload needs no reset.
  always_ff @(posedge clk_i) begin
    key_q <= key_d;
    idx_q <= idx_d;
  end

  assign valid_o = valid_q;
  assign key_o   = key_q;
  assign idx_o   = idx_q;

endmodule

FILE: hdl/sibk_checker.sv
// Port-level checker for the stable index sorter and its bind statement.
`include "assert_macros.svh"

module sibk_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_stall_o,
  input logic last_item_i,
  input logic out_valid_o,
  input logic out_stall_i,
  input logic last_result_o
);

  // No record is taken while results are being delivered.
  `SIBK_ASSERT_IMPL(a_stall_during_drain, out_valid_o, in_stall_o)

  // A marked record always starts the output in the next cycle.
  `SIBK_ASSERT_NEXT(a_last_starts_drain, in_valid_i && !in_stall_o && last_item_i, out_valid_o)

  // After the final result of a list the output goes idle.
  `SIBK_ASSERT_NEXT(a_idle_after_last, out_valid_o && !out_stall_i && last_result_o,
                    !out_valid_o)

endmodule

bind stable_index_sort_by_key sibk_checker u_sibk_checker (.*);
